>>> rtl/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// shared types, codes and helpers of the pattern blink sequencer
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int unsigned TimeBitsDef  = 32;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned DataBits     = 32;
  localparam int unsigned IdxBits      = 3;

  localparam logic [31:0] MeanderWord  = 32'h5555_5555;

  // command codes carried in func
  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_START   = 3'd1,
    FUNC_SET     = 3'd2,
    FUNC_TOGGLE  = 3'd3,
    FUNC_ENABLE  = 3'd4,
    FUNC_DISABLE = 3'd5
  } func_e;

  // run modes as reported on run_mode
  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_RESET    = 2'd1,
    MODE_SET      = 2'd2,
    MODE_SEQ      = 2'd3
  } mode_e;

  // configuration register indices
  typedef enum logic [IdxBits-1:0] {
    CFG_HIGH_TIME    = 3'd0,
    CFG_LOW_TIME     = 3'd1,
    CFG_PATTERN_WORD = 3'd2,
    CFG_REPEAT_COUNT = 3'd3,
    CFG_PATTERN_MODE = 3'd4,
    CFG_INVERT       = 3'd5,
    CFG_ACTIVE_LEVEL = 3'd6
  } cfg_idx_e;

  // physical pin level for a logical level
  function automatic logic pin_drive(logic logical, logic act_level, logic inv);
    return (logical == act_level) ^ inv;
  endfunction

endpackage

>>> rtl/pbs_if.sv
// ----------------------------------------------------------------------------
// pbs_if
// command and result channels of the pattern blink sequencer
// ----------------------------------------------------------------------------
interface pbs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] elapsed_ms;
  logic        level;

  modport source (output valid, output func, output elapsed_ms, output level,
                  input ready);
  modport sink   (input valid, input func, input elapsed_ms, input level,
                  output ready);
endinterface

interface pbs_out_if;
  logic        valid;
  logic        ready;
  logic        pin_out;
  logic [1:0]  run_mode;
  logic [31:0] remaining_ms;

  modport source (output valid, output pin_out, output run_mode,
                  output remaining_ms, input ready);
  modport sink   (input valid, input pin_out, input run_mode,
                  input remaining_ms, output ready);
endinterface

>>> rtl/pattern_blink_sequencer.sv
// ----------------------------------------------------------------------------
// pattern_blink_sequencer
// drives one pin from tick, start, set, toggle, enable and disable commands
// ----------------------------------------------------------------------------
// One command beat is taken every clock cycle for as long as the result side
// takes beats. Its whole effect on the sequencer state (dwell count,
// rotating pattern, step count, pin level) is worked out combinationally
// by one subtract and compare on the dwell counter and a one-bit rotate,
// and the state registers take it at the accepting edge. The result beat
// appears in the output register in the cycle after the command. A new
// command is let in when the output register is empty or its beat is taken
// in the same cycle. While a result beat waits, the next command is held
// off. Configuration is written through a plain write port while no
// command is in flight, a rule the user must keep that the block does not
// enforce. TIME_BITS and COUNT_BITS set the dwell timer and repeat widths.
// ----------------------------------------------------------------------------
module pattern_blink_sequencer #(
  parameter int unsigned TIME_BITS  = pbs_pkg::TimeBitsDef,
  parameter int unsigned COUNT_BITS = pbs_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pbs_in_if.sink                        in_i,
  pbs_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [pbs_pkg::IdxBits-1:0]   cfg_idx_i,
  input  logic [pbs_pkg::DataBits-1:0]  cfg_data_i
);
  import pbs_pkg::*;

  // steps: count times 32 (pattern) or times 2 (meander), plus the extra pause step
  localparam int unsigned StepBits = COUNT_BITS + 6;

  // configuration registers
  logic [TIME_BITS-1:0]  high_time_q, low_time_q;
  logic [31:0]           pattern_word_q;
  logic [COUNT_BITS-1:0] repeat_count_q;
  logic                  pattern_mode_q, invert_q, active_level_q;

  // sequencer state
  mode_e                 mode_q, mode_d;
  logic [TIME_BITS-1:0]  dwell_q, dwell_d;
  logic [31:0]           pat_q, pat_d;
  logic [StepBits-1:0]   steps_q, steps_d;
  logic                  forever_q, forever_d;
  logic                  inv_q, inv_d;
  logic                  pin_q, pin_d;

  // result register
  logic                  out_valid_q;
  logic                  out_pin_q;
  mode_e                 out_mode_q;
  logic [31:0]           out_rem_q;

  logic                  in_beat;
  logic [31:0]           dwell_ext;
  logic                  dwell_holds;
  logic [StepBits-1:0]   steps_dec;
  logic [31:0]           pat_rot;
  logic [31:0]           start_pat;
  logic                  start_forever;
  logic [StepBits-1:0]   start_steps;
  logic                  start_pin;

  // the output register frees up when its beat is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_beat    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_time_q    <= '0;
      low_time_q     <= '0;
      pattern_word_q <= MeanderWord;
      repeat_count_q <= '0;
      pattern_mode_q <= 1'b0;
      invert_q       <= 1'b0;
      active_level_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HIGH_TIME:    high_time_q    <= cfg_data_i[TIME_BITS-1:0];
        CFG_LOW_TIME:     low_time_q     <= cfg_data_i[TIME_BITS-1:0];
        CFG_PATTERN_WORD: pattern_word_q <= cfg_data_i[31:0];
        CFG_REPEAT_COUNT: repeat_count_q <= cfg_data_i[COUNT_BITS-1:0];
        CFG_PATTERN_MODE: pattern_mode_q <= cfg_data_i[0];
        CFG_INVERT:       invert_q       <= cfg_data_i[0];
        CFG_ACTIVE_LEVEL: active_level_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // tick arithmetic
  assign dwell_ext   = 32'(dwell_q);
  assign dwell_holds = dwell_ext >= in_i.elapsed_ms;
  assign steps_dec   = (!forever_q && steps_q != '0) ? steps_q - 1'b1 : steps_q;
  assign pat_rot     = {pat_q[0], pat_q[31:1]};

  // start: pattern source and step count
  assign start_pat     = pattern_mode_q ? pattern_word_q : MeanderWord;
  assign start_forever = (repeat_count_q == '1);
  assign start_steps   = start_forever ? '0 :
                         pattern_mode_q ? (StepBits'(repeat_count_q) << 5) :
                                          (StepBits'(repeat_count_q) << 1);

  always_comb begin
    mode_d    = mode_q;
    dwell_d   = dwell_q;
    pat_d     = pat_q;
    steps_d   = steps_q;
    forever_d = forever_q;
    inv_d     = inv_q;
    pin_d     = pin_q;
    start_pin = pin_q;
    case (func_e'(in_i.func))
      FUNC_TICK: begin
        if (dwell_holds) begin
          dwell_d = TIME_BITS'(dwell_ext - in_i.elapsed_ms);
        end else begin
          dwell_d = '0;
          if (mode_q == MODE_SET) begin
            pin_d = pin_drive(1'b1, active_level_q, inv_q);
          end else if (mode_q == MODE_SEQ) begin
            steps_d = steps_dec;
            if (forever_q || steps_dec != '0) begin
              pat_d   = pat_rot;
              dwell_d = pat_rot[0] ? high_time_q : low_time_q;
              pin_d   = pin_drive(pat_rot[0], active_level_q, inv_q);
            end else begin
              mode_d = MODE_RESET;
              pin_d  = pin_drive(1'b0, active_level_q, inv_q);
            end
          end else begin
            pin_d = pin_drive(1'b0, active_level_q, inv_q);
          end
        end
      end
      FUNC_START: begin
        // inversion is taken over at once, even by a running sequence
        inv_d = invert_q;
        if (mode_q == MODE_DISABLED) begin
          start_pin = pin_drive(1'b0, active_level_q, invert_q);
          pin_d     = start_pin;
          mode_d    = MODE_RESET;
        end
        if (mode_q != MODE_SEQ) begin
          pat_d     = start_pat;
          forever_d = start_forever;
          mode_d    = MODE_SEQ;
          if (start_pat[0] && (start_pin == active_level_q)) begin
            // pin already active: pause first
            steps_d = start_steps + StepBits'(!start_forever);
            dwell_d = low_time_q;
            pin_d   = pin_drive(1'b0, active_level_q, invert_q);
          end else begin
            steps_d = start_steps;
            dwell_d = start_pat[0] ? high_time_q : low_time_q;
            pin_d   = pin_drive(start_pat[0], active_level_q, invert_q);
          end
        end
      end
      FUNC_SET: begin
        dwell_d = '0;
        inv_d   = 1'b0;
        mode_d  = in_i.level ? MODE_SET : MODE_RESET;
        pin_d   = pin_drive(in_i.level, active_level_q, 1'b0);
      end
      FUNC_TOGGLE: begin
        dwell_d = '0;
        mode_d  = (pin_q == active_level_q) ? MODE_RESET : MODE_SET;
        pin_d   = pin_drive(pin_q != active_level_q, active_level_q, inv_q);
      end
      FUNC_ENABLE: begin
        mode_d = MODE_RESET;
        pin_d  = pin_drive(1'b0, active_level_q, inv_q);
      end
      FUNC_DISABLE: begin
        mode_d = MODE_DISABLED;
        pin_d  = pin_drive(1'b0, active_level_q, inv_q);
      end
      default: ;  // unused codes leave the state alone
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RESET;
      dwell_q   <= '0;
      pat_q     <= '0;
      steps_q   <= '0;
      forever_q <= 1'b0;
      inv_q     <= 1'b0;
      pin_q     <= 1'b0;
    end else if (in_beat) begin
      mode_q    <= mode_d;
      dwell_q   <= dwell_d;
      pat_q     <= pat_d;
      steps_q   <= steps_d;
      forever_q <= forever_d;
      inv_q     <= inv_d;
      pin_q     <= pin_d;
    end
  end

  // result beat valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded with the state after the command
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_pin_q  <= pin_d;
      out_mode_q <= mode_d;
      out_rem_q  <= 32'(dwell_d);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pin_out      = out_pin_q;
  assign out_o.run_mode     = out_mode_q;
  assign out_o.remaining_ms = out_rem_q;

endmodule

>>> rtl/pbs_chk.sv
// ----------------------------------------------------------------------------
// pbs_chk
// port-level checks of the pattern blink sequencer
// ----------------------------------------------------------------------------
module pbs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [2:0]  in_func_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_pin_i,
  input logic [1:0]  out_mode_i,
  input logic [31:0] out_rem_i
);
  import pbs_pkg::*;

  // an empty result register never blocks a command
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("command blocked with result register empty");

  // every command beat gives a result beat next cycle
  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("command beat without result beat");

  // disable always reports the disabled mode
  a_disable_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_func_i == FUNC_DISABLE |=>
      out_mode_i == MODE_DISABLED)
    else $error("disable did not report disabled mode");

  // a stalled result beat holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_pin_i) && $stable(out_mode_i) && $stable(out_rem_i))
    else $error("stalled result beat changed");

endmodule

bind pattern_blink_sequencer pbs_chk u_pbs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pin_i   (out_o.pin_out),
  .out_mode_i  (out_o.run_mode),
  .out_rem_i   (out_o.remaining_ms)
);
